// ===== rtl/core/fir100_pkg.sv =====
// Package for the 100-tap FIR filter core: fixed widths and the coefficient table.
// Depends on nothing; used by the interfaces, the tap cell and the top level.
`default_nettype none

package fir100_pkg;

   // Width of the filter result, fixed by the result beat format.
   localparam int OUT_BITS = 36;

   // Unsigned coefficient width; the largest coefficient (567.3) at 16 fractional
   // bits needs 26 bits.
   localparam int COEF_BITS = 26;

   // Number of distinct coefficients before the pattern repeats.
   localparam int COEF_PERIOD = 5;

   typedef logic [COEF_BITS-1:0] coef_type;

   // Fixed-point coefficient for tap index tap, rounded to nearest with halves up.
   // Only evaluated at elaboration.
   function automatic coef_type coef_fixed(input int tap, input int frac_bits);
      longint num;
      longint val;
      begin
         case (tap % COEF_PERIOD)
            0: begin
               num = longint'(145) <<< frac_bits;
               val = (num + 50) / 100;
            end
            1: begin
               num = longint'(4243) <<< frac_bits;
               val = (num + 500) / 1000;
            end
            2: begin
               num = longint'(5673) <<< frac_bits;
               val = (num + 5) / 10;
            end
            3: begin
               num = longint'(2454) <<< frac_bits;
               val = (num + 500) / 1000;
            end
            default: begin
               num = longint'(2345) <<< frac_bits;
               val = (num + 50) / 100;
            end
         endcase
         return val[COEF_BITS-1:0];
      end
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fir100_if.sv =====
// Valid/ready stream interfaces for the FIR core: sample beats in, result beats out.
// Depends on fir100_pkg for the result width.
`default_nettype none

interface fir100_req_if import fir100_pkg::*; #(
   parameter int SAMPLE_BITS = 16
);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

interface fir100_rsp_if import fir100_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [OUT_BITS-1:0] filtered;

   modport source (output valid, output filtered, input ready);
   modport sink (input valid, input filtered, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/fir100_cell.sv =====
// One tap of the transposed FIR chain: multiplies the current sample by its
// coefficient and adds the partial sum handed over by its upstream neighbor.
// Depends on fir100_pkg.
`default_nettype none

module fir100_cell import fir100_pkg::*; #(
   parameter int       SAMPLE_BITS = 16,
   parameter coef_type COEF        = '0
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [SAMPLE_BITS-1:0] sample,
   input  wire logic [OUT_BITS-1:0]    sum_in_chain,
   output logic      [OUT_BITS-1:0]    sum_out
);

   logic signed [OUT_BITS-1:0] product;
   logic        [OUT_BITS-1:0] sum_ff;
   logic        [OUT_BITS-1:0] sum_in;

   // The sum wraps modulo 2^OUT_BITS, so the product is formed at that width.
   assign product = OUT_BITS'($signed(sample)) * OUT_BITS'($signed({1'b0, COEF}));
   assign sum_in  = sum_in_chain + product;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff <= '0;
      end else if (advance) begin
         sum_ff <= sum_in;
      end
   end

   assign sum_out = sum_ff;

endmodule

`default_nettype wire

// ===== rtl/core/fir_filter_100_tap_core.sv =====
// Top level of the 100-tap FIR filter core: a chain of tap cells in transposed form.
// Depends on fir100_pkg, fir100_if (fir100_req_if, fir100_rsp_if) and fir100_cell.
//
// Usage. Signed samples arrive as beats on req_bus (valid/ready); every sample
// gives exactly one result beat on rsp_bus, carrying the full-precision sum of
// coefficient times sample over the last TAPS samples, with COEF_FRAC_BITS
// fractional bits. The coefficients repeat 1.45, 4.243, 567.3, 2.454, 23.45.
// The result is registered and shows in the cycle after its sample is accepted.
// Throughput is one beat per cycle while the receiver takes results; each cell
// does one multiply and one add per accepted sample, and that multiply-add is the
// path between registers. Cell 0's sum register doubles as the result register.
// The core takes a new sample whenever that register is empty or its result is
// taken in the same cycle. When the receiver stalls, the result holds and the
// whole chain freezes, so req_bus.ready drops until the result beat leaves.
// Reset (synchronous, active high) clears every partial sum, which matches a
// sample history of all zeros, and empties the result register.
`default_nettype none

module fir_filter_100_tap_core import fir100_pkg::*; #(
   parameter int TAPS           = 100,
   parameter int SAMPLE_BITS    = 16,
   parameter int COEF_FRAC_BITS = 6
) (
   input wire logic    clock,
   input wire logic    reset,
   fir100_req_if.sink  req_bus,
   fir100_rsp_if.source rsp_bus
);

   // sum_chain[k] is cell k's registered partial sum; the entry past the last
   // cell is the zero that feeds the oldest tap.
   logic [OUT_BITS-1:0] sum_chain [0:TAPS];
   logic                accept;
   logic                out_valid_ff;
   logic                out_valid_in;

   // A sample moves the chain only when the result register can take a new value.
   assign req_bus.ready = !out_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   assign sum_chain[TAPS] = '0;

   // Cell k adds coefficient k times the new sample to the sum from cell k+1,
   // so cell 0 ends up with the full filter output for that sample.
   for (genvar k = 0; k < TAPS; k++) begin : g_tap
      fir100_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .COEF        (coef_fixed(k, COEF_FRAC_BITS))
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .advance      (accept),
         .sample       (req_bus.sample),
         .sum_in_chain (sum_chain[k+1]),
         .sum_out      (sum_chain[k])
      );
   end

   // The result register fills on every accepted sample and empties when taken.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (accept) begin
         out_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_bus.valid    = out_valid_ff;
   assign rsp_bus.filtered = sum_chain[0];

   // Every accepted sample leaves a result waiting at the next edge.
   a_accept_gives_result : assert property (@(posedge clock) disable iff (reset)
      accept |=> out_valid_ff)
      else $error("accepted sample did not produce a result");

   // With nothing accepted, a result that is taken is not replaced by another.
   a_no_extra_result : assert property (@(posedge clock) disable iff (reset)
      (!accept && rsp_bus.ready) |=> !out_valid_ff)
      else $error("result appeared without an accepted sample");

   // While the result is stalled, cell 1's partial sum inside the chain stays put.
   a_chain_frozen_on_stall : assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_bus.ready) |=> $stable(sum_chain[1]))
      else $error("tap chain moved while the result was stalled");

   // Reset clears cell 1's partial sum, matching an all-zero history, and the result.
   a_reset_clears_chain : assert property (@(posedge clock)
      reset |=> (sum_chain[1] == '0) && !out_valid_ff)
      else $error("tap chain not cleared by reset");

endmodule

`default_nettype wire
